// ===== rtl/irds_pkg.sv =====
// Shared types and constants for the irrigation run and dose sequencer.
// Item structs for both channels, event kinds and run state codes.
// No dependencies.
`timescale 1ns / 1ps

package irds_pkg;

   localparam int ELAPSED_W = 17;
   localparam int TIME_W    = 32;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [7:0]           TICK_DELTA_RESET = 8'd5;

   localparam logic [2:0] KIND_TICK    = 3'd0;
   localparam logic [2:0] KIND_POWER   = 3'd1;
   localparam logic [2:0] KIND_START   = 3'd2;
   localparam logic [2:0] KIND_MANUAL  = 3'd3;
   localparam logic [2:0] KIND_RELEASE = 3'd4;

   localparam logic [1:0] RUN_IDLE  = 2'd0;
   localparam logic [1:0] RUN_RUN   = 2'd1;
   localparam logic [1:0] RUN_PAUSE = 2'd2;

   localparam logic [1:0] DOSE_AT_START = 2'd0;
   localparam logic [1:0] DOSE_AT_MID   = 2'd1;
   localparam logic [1:0] DOSE_AT_END   = 2'd2;

   typedef struct packed {
      logic [2:0]           kind;
      logic [TIME_W-1:0]    now_sec;
      logic                 power_ok;
      logic [7:0]           valve_mask;
      logic [ELAPSED_W-1:0] run_target_sec;
      logic                 dose_enable;
      logic [1:0]           dose_timing;
      logic [ELAPSED_W-1:0] dose_duration_sec;
      logic                 keep_dosing;
   } req_item_type;

   typedef struct packed {
      logic [7:0]           valves;
      logic                 dosing_on;
      logic [1:0]           run_state;
      logic [ELAPSED_W-1:0] elapsed_sec;
      logic                 sequence_done;
      logic                 clock_resync;
      logic                 queued_pending;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]           valves;
      logic [ELAPSED_W-1:0] target;
      logic                 dose_en;
      logic [1:0]           timing;
      logic [ELAPSED_W-1:0] dose_len;
   } seq_type;

endpackage

// ===== rtl/irrigation_run_dose_sequencer_unit.sv =====
// Irrigation run and dose sequencer, top level.
// Stages: input register, then state update and result register.
// Throughput: one item per cycle when the result side is not stalled.
// Stall on the result side holds both stages; the input side stalls only when both are full.
// Reset (synchronous, active high): idle, no tick seen, power present, relays off,
// queue empty, tick gap limit 5; both stages empty.
`timescale 1ns / 1ps

module irrigation_run_dose_sequencer_unit #(
   parameter int VALVE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  irds_pkg::req_item_type  req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output irds_pkg::rsp_item_type  rsp_item,
   input  logic                    csr_wr_en,
   input  logic [7:0]              csr_wr_data
);
   import irds_pkg::*;

   localparam logic [7:0] VALVE_KEEP =
      (VALVE_BITS >= 8) ? 8'hFF : 8'((64'd1 << VALVE_BITS) - 64'd1);

   logic                 advance;
   logic                 in_valid_ff, in_valid_in;
   req_item_type         in_item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic [7:0]           max_delta_ff;

   logic [1:0]           mode_ff, mode_in;
   logic [TIME_W-1:0]    last_tick_ff, last_tick_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 power_ff, power_in;
   seq_type              active_ff, active_in;
   logic                 queued_valid_ff, queued_valid_in;
   seq_type              queued_ff, queued_in;
   logic [7:0]           valve_drive_ff, valve_drive_in;
   logic                 dose_drive_ff, dose_drive_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign in_valid_in  = (advance || !in_valid_ff) ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_comb begin
      seq_type              req_seq;
      logic [TIME_W-1:0]    base;
      logic [TIME_W-1:0]    gap;
      logic [ELAPSED_W:0]   sum;
      logic [ELAPSED_W-1:0] new_elapsed;
      logic [ELAPSED_W-1:0] open;
      logic [ELAPSED_W:0]   close;
      logic                 done;
      logic                 resync;

      req_seq.valves   = in_item_ff.valve_mask & VALVE_KEEP;
      req_seq.target   = in_item_ff.run_target_sec;
      req_seq.dose_en  = in_item_ff.dose_enable;
      req_seq.timing   = in_item_ff.dose_timing;
      req_seq.dose_len = in_item_ff.dose_duration_sec;

      mode_in         = mode_ff;
      last_tick_in    = last_tick_ff;
      elapsed_in      = elapsed_ff;
      power_in        = power_ff;
      active_in       = active_ff;
      queued_valid_in = queued_valid_ff;
      queued_in       = queued_ff;
      valve_drive_in  = valve_drive_ff;
      dose_drive_in   = dose_drive_ff;
      done            = 1'b0;
      resync          = 1'b0;

      base = (last_tick_ff == '0) ? in_item_ff.now_sec : last_tick_ff;
      gap  = in_item_ff.now_sec - base;
      sum  = {1'b0, elapsed_ff} + {{(ELAPSED_W - 7){1'b0}}, gap[7:0]};
      new_elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];

      case (active_ff.timing)
         DOSE_AT_MID: open = active_ff.target >> 1;
         DOSE_AT_END: open = (active_ff.target > active_ff.dose_len) ?
                             (active_ff.target - active_ff.dose_len) : '0;
         default:     open = '0;
      endcase
      close = {1'b0, open} + {1'b0, active_ff.dose_len};

      case (in_item_ff.kind)
         KIND_TICK: begin
            last_tick_in = in_item_ff.now_sec;
            if (gap > {24'd0, max_delta_ff}) begin
               resync = 1'b1;
            end else if (mode_ff == RUN_RUN && gap != '0) begin
               elapsed_in    = new_elapsed;
               dose_drive_in = active_ff.dose_en && (new_elapsed >= open) &&
                               ({1'b0, new_elapsed} < close);
               if (new_elapsed >= active_ff.target) begin
                  done           = 1'b1;
                  valve_drive_in = '0;
                  dose_drive_in  = 1'b0;
                  mode_in        = RUN_IDLE;
                  if (queued_valid_ff) begin
                     queued_valid_in = 1'b0;
                     active_in       = queued_ff;
                     elapsed_in      = '0;
                     mode_in         = RUN_RUN;
                     valve_drive_in  = queued_ff.valves;
                  end
               end
            end
         end
         KIND_POWER: begin
            if (in_item_ff.power_ok != power_ff) begin
               power_in = in_item_ff.power_ok;
               if (!in_item_ff.power_ok) begin
                  if (mode_ff == RUN_RUN) begin
                     valve_drive_in = '0;
                     dose_drive_in  = 1'b0;
                     mode_in        = RUN_PAUSE;
                  end
               end else if (mode_ff == RUN_PAUSE) begin
                  valve_drive_in = active_ff.valves;
                  mode_in        = RUN_RUN;
               end
            end
         end
         KIND_START: begin
            if (mode_ff == RUN_IDLE) begin
               active_in      = req_seq;
               elapsed_in     = '0;
               mode_in        = RUN_RUN;
               valve_drive_in = req_seq.valves;
            end else begin
               queued_in       = req_seq;
               queued_valid_in = 1'b1;
            end
         end
         KIND_MANUAL: begin
            valve_drive_in = req_seq.valves;
            if (!in_item_ff.keep_dosing) begin
               dose_drive_in = 1'b0;
            end
         end
         KIND_RELEASE: begin
            if (mode_ff == RUN_RUN) begin
               valve_drive_in = active_ff.valves;
            end else begin
               valve_drive_in = '0;
               dose_drive_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase

      rsp_item_in.valves         = valve_drive_in;
      rsp_item_in.dosing_on      = dose_drive_in;
      rsp_item_in.run_state      = mode_in;
      rsp_item_in.elapsed_sec    = elapsed_in;
      rsp_item_in.sequence_done  = done;
      rsp_item_in.clock_resync   = resync;
      rsp_item_in.queued_pending = queued_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         max_delta_ff    <= TICK_DELTA_RESET;
         mode_ff         <= RUN_IDLE;
         last_tick_ff    <= '0;
         elapsed_ff      <= '0;
         power_ff        <= 1'b1;
         active_ff       <= '0;
         queued_valid_ff <= 1'b0;
         queued_ff       <= '0;
         valve_drive_ff  <= '0;
         dose_drive_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_delta_ff <= csr_wr_data;
         end
         if (advance && in_valid_ff) begin
            mode_ff         <= mode_in;
            last_tick_ff    <= last_tick_in;
            elapsed_ff      <= elapsed_in;
            power_ff        <= power_in;
            active_ff       <= active_in;
            queued_valid_ff <= queued_valid_in;
            queued_ff       <= queued_in;
            valve_drive_ff  <= valve_drive_in;
            dose_drive_ff   <= dose_drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance || !in_valid_ff) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

// ===== rtl/irds_checker.sv =====
// Port-level checks for the irrigation run and dose sequencer.
// Depends on irds_pkg; bound to irrigation_run_dose_sequencer_unit below.
`timescale 1ns / 1ps

module irds_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input irds_pkg::rsp_item_type rsp_item
);
   import irds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.sequence_done |-> !rsp_item.clock_resync)
      else $error("completion and resync on the same tick");

   a_done_drains_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.sequence_done |-> !rsp_item.queued_pending)
      else $error("queue still pending after a completion");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind irrigation_run_dose_sequencer_unit irds_checker u_irds_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
